/* src/dssm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssm_pkg
// Shared types and codes for the dual stack shared memory core.
// ----------------------------------------------------------------------------
package dssm_pkg;

   localparam int DEPTH_DEFAULT = 256;
   localparam int WORD_W        = 32;
   localparam int COUNT_W       = 9;
   localparam int STATUS_W      = 2;
   localparam int KIND_W        = 2;

   // request kinds
   localparam logic [KIND_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [KIND_W-1:0] OP_POP   = 2'd1;
   localparam logic [KIND_W-1:0] OP_TOP   = 2'd2;
   localparam logic [KIND_W-1:0] OP_CLEAR = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

   // memory strobes from control to storage
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

   // per-request outcome from control to the output stage
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                is_read;
      logic [COUNT_W-1:0]  front_count;
      logic [COUNT_W-1:0]  back_count;
   } result_type;

endpackage

/* src/dssm_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssm_store
// Single-port word store, synchronous write, registered read.
// ----------------------------------------------------------------------------
module dssm_store
   import dssm_pkg::*;
#(
   parameter  int DEPTH = DEPTH_DEFAULT,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  mem_cmd_type       mem_cmd,
   input  logic [AW-1:0]     mem_addr,
   input  logic [WORD_W-1:0] mem_wdata,
   output logic [WORD_W-1:0] mem_rdata
);

   logic [WORD_W-1:0] store_mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         store_mem[mem_addr] <= mem_wdata;
      end
   end

   // read data holds until the next read strobe
   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rdata_ff <= store_mem[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

/* src/dssm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dssm_ctrl
// Stack levels, full/empty decode and store address generation.
// ----------------------------------------------------------------------------
module dssm_ctrl
   import dssm_pkg::*;
#(
   parameter  int DEPTH = DEPTH_DEFAULT,
   localparam int AW    = $clog2(DEPTH),
   localparam int LW    = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [KIND_W-1:0] req_kind,
   input  logic              req_side,
   output mem_cmd_type       mem_cmd,
   output logic [AW-1:0]     mem_addr,
   output result_type        result
);

   logic [LW-1:0] front_ff, front_in;
   logic [LW-1:0] back_ff, back_in;
   logic [LW:0]   used;
   logic [LW-1:0] level;
   logic [LW-1:0] addr_full;
   logic          full;
   logic          empty;

   assign used  = {1'b0, front_ff} + {1'b0, back_ff};
   assign full  = used >= (LW + 1)'(DEPTH);
   assign level = req_side ? back_ff : front_ff;
   assign empty = level == '0;

   always_comb begin
      front_in       = front_ff;
      back_in        = back_ff;
      addr_full      = '0;
      mem_cmd.wr_en  = 1'b0;
      mem_cmd.rd_en  = 1'b0;
      result.status  = ST_OK;
      result.is_read = 1'b0;
      case (req_kind)
         OP_PUSH: begin
            if (full) begin
               result.status = ST_OVERFLOW;
            end else begin
               mem_cmd.wr_en = accept;
               if (req_side) begin
                  addr_full = LW'(DEPTH - 1) - back_ff;
                  back_in   = back_ff + LW'(1);
               end else begin
                  addr_full = front_ff;
                  front_in  = front_ff + LW'(1);
               end
            end
         end
         OP_POP, OP_TOP: begin
            if (empty) begin
               result.status = ST_EMPTY;
            end else begin
               mem_cmd.rd_en  = accept;
               result.is_read = 1'b1;
               addr_full      = req_side ? LW'(DEPTH) - level : level - LW'(1);
               if (req_kind == OP_POP) begin
                  if (req_side) begin
                     back_in = back_ff - LW'(1);
                  end else begin
                     front_in = front_ff - LW'(1);
                  end
               end
            end
         end
         default: begin
            // clear: level only, store keeps its contents
            if (req_side) begin
               back_in = '0;
            end else begin
               front_in = '0;
            end
         end
      endcase
      result.front_count = COUNT_W'(front_in);
      result.back_count  = COUNT_W'(back_in);
   end

   assign mem_addr = addr_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
      end
   end

   a_levels_fit: assert property (@(posedge clock) disable iff (reset)
      used <= (LW + 1)'(DEPTH))
      else $error("stack levels exceed store depth");

   a_front_pop: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == OP_POP && !req_side && !empty
      |=> front_ff == $past(front_ff) - LW'(1))
      else $error("front pop did not decrement level");

   a_full_no_write: assert property (@(posedge clock) disable iff (reset)
      full |-> !mem_cmd.wr_en)
      else $error("store written while stacks meet");

endmodule

/* src/dual_stack_shared_memory_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_stack_shared_memory_core
// Two LIFO stacks sharing one word store, front growing up, back growing down.
// ----------------------------------------------------------------------------
// Usage:
//  - Request beats arrive on req_*: tuser carries the kind (push, pop, top,
//    clear) and the side, tdata the word to push.
//  - Each request beat yields exactly one response beat on rsp_*: the popped
//    or top word (zero otherwise), a status in tuser (ok, overflow, empty)
//    and both stack counts after the request.
//  - Latency: the response is valid the cycle after the request is taken.
//  - Throughput: one request per cycle. Levels update at the accept edge and
//    the store takes its single write or read in the same edge, so the next
//    request always sees the finished state; no forwarding is needed.
//  - The read word comes from the store's registered read port, which holds
//    its value until the next read, so it stays put while a response waits.
//  - Stall: with a response held (rsp_tready low) req_tready drops; once
//    the response drains a new request is taken in the same cycle.
//  - Reset clears both levels and the response valid. The store is not
//    cleared; pop and top only ever read entries their own side wrote.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory_core
   import dssm_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] push_value
   input  logic [2:0]  req_tuser,  // [1:0] req_type, [2] side
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // [31:0] data_word, [40:32] front_count,
                                   // [49:41] back_count, [55:50] zero
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   localparam int AW = $clog2(DEPTH);

   logic              accept;
   mem_cmd_type       mem_cmd;
   logic [AW-1:0]     mem_addr;
   logic [WORD_W-1:0] mem_rdata;
   result_type        result;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff;
   logic [WORD_W-1:0] data_word;

   // output slot frees up in the same cycle it drains
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   dssm_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_kind (req_tuser[1:0]),
      .req_side (req_tuser[2]),
      .mem_cmd  (mem_cmd),
      .mem_addr (mem_addr),
      .result   (result)
   );

   dssm_store #(.DEPTH(DEPTH)) u_store (
      .clock     (clock),
      .mem_cmd   (mem_cmd),
      .mem_addr  (mem_addr),
      .mem_wdata (req_tdata),
      .mem_rdata (mem_rdata)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result;
      end
   end

   // store read data is valid only for a successful pop or top
   assign data_word  = result_ff.is_read ? mem_rdata : '0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, result_ff.back_count, result_ff.front_count, data_word};
   assign rsp_tuser  = result_ff.status;

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_tvalid)
      else $error("accepted request produced no response");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");

   a_read_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.is_read |-> result_ff.status == ST_OK)
      else $error("store data returned with error status");

endmodule
